[rtl/core/blm_pkg.sv]
`timescale 1ns / 1ps

package blm_pkg;

  // Field and state widths
  localparam int ADC_BITS    = 12;
  localparam int INTERVAL_W  = 16;
  localparam int LEVEL_W     = 20;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 20;
  localparam int TAKEN_W     = 8;
  localparam int STREAK_W    = 2;

  // Averaging and shutdown policy
  localparam logic [TAKEN_W-1:0]  SAMPLES_PER_AVERAGE = 8'd200;
  localparam logic [STREAK_W-1:0] LOW_LIMIT           = 2'd3;

  // Restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = LEVEL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LEVEL      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL       = 8'd3;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd10;
  localparam logic [LEVEL_W-1:0]    DIVISOR_RST  = 20'd200;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic finish;
    logic emit;
  } blm_cmd_t;

  typedef struct packed {
    logic avg_due;
    logic out_free;
  } blm_status_t;

endpackage

[rtl/core/blm_ctrl.sv]
`timescale 1ns / 1ps

module blm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  blm_pkg::blm_status_t status_i,
  output blm_pkg::blm_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [blm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.avg_due) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == blm_pkg::DIV_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/core/blm_datapath.sv]
`timescale 1ns / 1ps

module blm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [blm_pkg::ADC_BITS-1:0]        adc_sample_i,
  input  logic                                cfg_valid_i,
  input  logic [blm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [blm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                level_valid_o,
  output logic [blm_pkg::LEVEL_W-1:0]         level_o,
  output logic                                warn_active_o,
  output logic                                shutdown_o,
  input  blm_pkg::blm_cmd_t                   cmd_i,
  output blm_pkg::blm_status_t                status_o
);

  localparam int LW = blm_pkg::LEVEL_W;

  // Configuration registers
  logic [blm_pkg::INTERVAL_W-1:0] interval_cfg_q;
  logic [LW-1:0]                  divisor_q;
  logic [LW-1:0]                  warn_level_q;
  logic [LW-1:0]                  off_level_q;

  // Monitor state
  logic [blm_pkg::INTERVAL_W-1:0] ticks_q;
  logic [LW-1:0]                  sum_q;
  logic [blm_pkg::TAKEN_W-1:0]    taken_q;
  logic [LW-1:0]                  last_level_q;
  logic [blm_pkg::STREAK_W-1:0]   streak_q;
  logic                           warn_q;
  logic                           shutdown_q;
  logic                           avg_q;

  // Divider
  logic [LW-1:0] rem_q;
  logic [LW-1:0] quo_q;

  // Output register
  logic          out_valid_q;
  logic          out_lv_q;
  logic [LW-1:0] out_level_q;
  logic          out_warn_q;
  logic          out_shutdown_q;

  logic [blm_pkg::INTERVAL_W-1:0] ticks_inc;
  logic                           take;
  logic [LW:0]                    sum_wide;
  logic [LW-1:0]                  sum_sat;
  logic [blm_pkg::TAKEN_W-1:0]    taken_inc;
  logic [LW:0]                    trial;
  logic [LW+1:0]                  diff;
  logic                           ge;
  logic                           is_low;
  logic [blm_pkg::STREAK_W-1:0]   streak_next;

  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  assign take      = (ticks_inc >= interval_cfg_q);
  assign sum_wide  = {1'b0, sum_q} + (LW+1)'(adc_sample_i);
  assign sum_sat   = sum_wide[LW] ? '1 : sum_wide[LW-1:0];
  assign taken_inc = taken_q + 1'b1;

  // One restoring step: shift in the next dividend bit and try the subtract.
  // A zero divisor always succeeds, so the quotient comes out all ones.
  assign trial = {rem_q, quo_q[LW-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_q};
  assign ge    = ~diff[LW+1];

  assign is_low      = (quo_q <= off_level_q);
  assign streak_next = !is_low ? '0 :
                       (streak_q < blm_pkg::LOW_LIMIT) ? streak_q + 1'b1 : streak_q;

  assign status_o.avg_due  = avg_q;
  assign status_o.out_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign level_valid_o = out_lv_q;
  assign level_o       = out_level_q;
  assign warn_active_o = out_warn_q;
  assign shutdown_o    = out_shutdown_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_cfg_q <= blm_pkg::INTERVAL_RST;
      divisor_q      <= blm_pkg::DIVISOR_RST;
      warn_level_q   <= '0;
      off_level_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        blm_pkg::REG_SAMPLE_INTERVAL: interval_cfg_q <= cfg_data_i[blm_pkg::INTERVAL_W-1:0];
        blm_pkg::REG_SCALE_DIVISOR:   divisor_q      <= cfg_data_i;
        blm_pkg::REG_WARN_LEVEL:      warn_level_q   <= cfg_data_i;
        blm_pkg::REG_OFF_LEVEL:       off_level_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q      <= '0;
      sum_q        <= '0;
      taken_q      <= '0;
      last_level_q <= '0;
      streak_q     <= '0;
      warn_q       <= 1'b0;
      shutdown_q   <= 1'b0;
      avg_q        <= 1'b0;
    end else if (cmd_i.accept) begin
      if (take) begin
        ticks_q <= '0;
        sum_q   <= sum_sat;
        taken_q <= taken_inc;
        avg_q   <= (taken_inc >= blm_pkg::SAMPLES_PER_AVERAGE);
      end else begin
        ticks_q <= ticks_inc;
        avg_q   <= 1'b0;
      end
    end else if (cmd_i.finish) begin
      last_level_q <= quo_q;
      warn_q       <= (quo_q < warn_level_q);
      streak_q     <= streak_next;
      if (streak_next >= blm_pkg::LOW_LIMIT) begin
        shutdown_q <= 1'b1;
      end
      sum_q   <= '0;
      taken_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[LW-1:0] : trial[LW-1:0];
      quo_q <= {quo_q[LW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // On an average tick, finish has set the level and flags before the beat is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_lv_q       <= 1'b0;
      out_level_q    <= '0;
      out_warn_q     <= 1'b0;
      out_shutdown_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_lv_q       <= avg_q;
      out_level_q    <= last_level_q;
      out_warn_q     <= warn_q;
      out_shutdown_q <= shutdown_q;
    end
  end

endmodule

[rtl/core/battery_level_monitor.sv]
`timescale 1ns / 1ps

// Averaging undervoltage monitor. Each input beat is one millisecond tick carrying
// the converter reading; every accepted beat yields exactly one output beat.
// Input channel: in_valid_i / in_stall_o with adc_sample_i. Output channel:
// out_valid_o / out_stall_i with level_valid_o, level_o, warn_active_o, shutdown_o.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; write
// only while no tick is in flight. Unknown indexes are ignored.
// An ordinary tick passes from acceptance through a check state to the emit state.
// A tick that completes an average also passes through the restoring divider, one
// quotient bit per cycle over the 20-bit level, and a finish step that updates the
// level and flags before the emit.
// One tick is processed at a time. The next tick may be taken while the previous
// result waits at the output.
// If the receiver stalls, the output beat holds and the next result waits in the
// controller until the output register frees.
// Reset clears the configuration to its defaults (interval 10, divisor 200,
// thresholds 0), the sum, counters, level, warning and the shutdown latch.
module battery_level_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [blm_pkg::ADC_BITS-1:0]     adc_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             level_valid_o,
  output logic [blm_pkg::LEVEL_W-1:0]      level_o,
  output logic                             warn_active_o,
  output logic                             shutdown_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [blm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [blm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  blm_pkg::blm_cmd_t    cmd;
  blm_pkg::blm_status_t status;

  assign cfg_ready_o = 1'b1;

  blm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  blm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adc_sample_i  (adc_sample_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .level_valid_o (level_valid_o),
    .level_o       (level_o),
    .warn_active_o (warn_active_o),
    .shutdown_o    (shutdown_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

[rtl/core/blm_checker.sv]
`timescale 1ns / 1ps

module blm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic level_valid_o,
  input logic shutdown_o
);

  // A stalled output beat is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // Ticks are processed one at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the previous tick finished");

  // The shutdown latch only clears at reset.
  a_shutdown_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shutdown_o |=> shutdown_o)
    else $error("shutdown released without reset");

  // A fresh level cannot be reported without the block having produced
  // an output beat.
  a_level_flag_with_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(level_valid_o) |-> out_valid_o)
    else $error("level flag changed without an output beat");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .level_valid_o (level_valid_o),
  .shutdown_o    (shutdown_o)
);
